// ===== rtl/owik_pkg.sv =====
// ============================================================================
// owik_pkg: shared types and constants of the omni-wheel kinematics block
// Fixed-point formats, payload structs and the divider interface types.
// ============================================================================
package owik_pkg;

  // Command and result widths.
  localparam int CMD_W      = 16;
  localparam int OUT_W      = 16;
  localparam int LANES      = 3;

  // Configuration register widths and reset values.
  localparam int LIMIT_W    = 15;
  localparam int RADIUS_W   = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(8000);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(256);

  // Q1.15 coefficients; the Q3.8 radius is moved to Q15 by a shift.
  localparam int COEF_W       = 16;
  localparam int FRAC_W       = 15;
  localparam int RADIUS_SHIFT = 7;
  localparam int TRUNC_BIAS   = (1 << FRAC_W) - 1;
  localparam logic signed [COEF_W-1:0] COEF_HALF       = 16'sd16384;
  localparam logic signed [COEF_W-1:0] COEF_SQRT3_HALF = 16'sd28378;

  // Datapath widths derived from the command width.
  localparam int PROD_W     = CMD_W + COEF_W;
  localparam int ROT_W      = CMD_W + RADIUS_W + 1;
  localparam int SUM_W      = CMD_W + 20;
  localparam int WHEEL_W    = SUM_W - FRAC_W;
  localparam int NUM_W      = WHEEL_W + LIMIT_W;
  localparam int QUO_W      = LIMIT_W;
  localparam int DIV_STAGES = QUO_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED_LIMIT  = 1'b0,
    CFG_WHEEL_RADIUS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CMD_W-1:0] command_x;
    logic signed [CMD_W-1:0] command_y;
    logic signed [CMD_W-1:0] command_turn;
    logic                    motors_online;
  } cmd_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] wheel_speed_0;
    logic signed [OUT_W-1:0] wheel_speed_1;
    logic signed [OUT_W-1:0] wheel_speed_2;
    logic                    was_limited;
    logic                    stopped;
  } wheel_t;

  // Per-word information that rides alongside the divider lanes.
  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][OUT_W-1:0] wlow;
    logic                        limited;
    logic                        stopped;
  } div_side_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] num;
    logic [WHEEL_W-1:0]          divisor;
    div_side_t                   side;
  } div_in_t;

  typedef struct packed {
    logic [LANES-1:0][QUO_W-1:0] quo;
    div_side_t                   side;
  } div_out_t;

endpackage

// ===== rtl/owik_divider.sv =====
// ============================================================================
// owik_divider: three-lane pipelined restoring divider
// One quotient bit per stage; the dividend is known to be below divisor << QUO_W.
// ============================================================================
module owik_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  owik_pkg::div_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output owik_pkg::div_out_t out_data_o
);

  logic [owik_pkg::DIV_STAGES-1:0] vld_q;
  logic [owik_pkg::DIV_STAGES-1:0] rdy;
  logic [owik_pkg::NUM_W-1:0]      rem_q  [owik_pkg::DIV_STAGES][owik_pkg::LANES];
  logic [owik_pkg::QUO_W-1:0]      quo_q  [owik_pkg::DIV_STAGES][owik_pkg::LANES];
  logic [owik_pkg::WHEEL_W-1:0]    dvs_q  [owik_pkg::DIV_STAGES];
  owik_pkg::div_side_t             side_q [owik_pkg::DIV_STAGES];

  for (genvar s = 0; s < owik_pkg::DIV_STAGES; s++) begin : g_stage
    logic                         prev_vld;
    logic [owik_pkg::NUM_W-1:0]   prev_rem [owik_pkg::LANES];
    logic [owik_pkg::QUO_W-1:0]   prev_quo [owik_pkg::LANES];
    logic [owik_pkg::WHEEL_W-1:0] prev_dvs;
    owik_pkg::div_side_t          prev_side;
    logic [owik_pkg::NUM_W-1:0]   trial;
    logic [owik_pkg::NUM_W-1:0]   rem_d [owik_pkg::LANES];
    logic [owik_pkg::QUO_W-1:0]   quo_d [owik_pkg::LANES];

    if (s == 0) begin : g_first
      always_comb begin
        prev_vld  = in_valid_i;
        prev_dvs  = in_data_i.divisor;
        prev_side = in_data_i.side;
        for (int k = 0; k < owik_pkg::LANES; k++) begin
          prev_rem[k] = in_data_i.num[k];
          prev_quo[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        prev_vld  = vld_q[s-1];
        prev_dvs  = dvs_q[s-1];
        prev_side = side_q[s-1];
        for (int k = 0; k < owik_pkg::LANES; k++) begin
          prev_rem[k] = rem_q[s-1][k];
          prev_quo[k] = quo_q[s-1][k];
        end
      end
    end

    if (s == owik_pkg::DIV_STAGES - 1) begin : g_last_rdy
      assign rdy[s] = ~vld_q[s] | out_ready_i;
    end else begin : g_mid_rdy
      assign rdy[s] = ~vld_q[s] | rdy[s+1];
    end

    // Trial subtraction of the divisor aligned to this stage's quotient bit.
    assign trial = owik_pkg::NUM_W'(prev_dvs) << (owik_pkg::QUO_W - 1 - s);

    always_comb begin
      for (int k = 0; k < owik_pkg::LANES; k++) begin
        if (prev_rem[k] >= trial) begin
          rem_d[k] = prev_rem[k] - trial;
          quo_d[k] = {prev_quo[k][owik_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_d[k] = prev_rem[k];
          quo_d[k] = {prev_quo[k][owik_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && prev_vld) begin
        dvs_q[s]  <= prev_dvs;
        side_q[s] <= prev_side;
        for (int k = 0; k < owik_pkg::LANES; k++) begin
          rem_q[s][k] <= rem_d[k];
          quo_q[s][k] <= quo_d[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[owik_pkg::DIV_STAGES-1];

  always_comb begin
    out_data_o.side = side_q[owik_pkg::DIV_STAGES-1];
    for (int k = 0; k < owik_pkg::LANES; k++) begin
      out_data_o.quo[k] = quo_q[owik_pkg::DIV_STAGES-1][k];
    end
  end

  // The final remainder of every lane must lie below the divisor.
  logic rem_ok;

  always_comb begin
    rem_ok = 1'b1;
    for (int k = 0; k < owik_pkg::LANES; k++) begin
      if (rem_q[owik_pkg::DIV_STAGES-1][k] >= dvs_q[owik_pkg::DIV_STAGES-1]) begin
        rem_ok = 1'b0;
      end
    end
  end

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (dvs_q[owik_pkg::DIV_STAGES-1] != '0) |-> rem_ok)
    else $error("divider remainder not below divisor");

  a_stall_keeps_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !rdy[0] |=> vld_q[0])
    else $error("stalled divider stage dropped its word");

  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q) && !out_ready_i)
    else $error("divider refused input with a free stage");

endmodule

// ===== rtl/omni_wheel_inverse_kinematics.sv =====
// ============================================================================
// omni_wheel_inverse_kinematics: three-wheel omni chassis wheel speeds
// Maps a chassis velocity command to three wheel speeds, scales them down to
// the configured limit and forces zeros when a motor is offline.
// ============================================================================
//
//  Channel   Direction  Handshake                Word
//  --------  ---------  -----------------------  -----------------------------
//  in        input      in_valid_i/in_ready_o    owik_pkg::cmd_t command
//  out       output     out_valid_o/out_ready_i  owik_pkg::wheel_t speeds
//  cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// The block takes one word per cycle unless the output stalls. Each word passes through
// four front stages (products, wheel sums, magnitudes and maximum, limit
// products), fifteen divider stages of one quotient bit each, and the output
// register. A stage loads when it is empty or its successor moves, so bubbles
// close up during an output stall. Reset empties the pipeline and loads the
// register defaults (limit 8000, radius 1.0); configuration writes are always taken.
//
module omni_wheel_inverse_kinematics (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  owik_pkg::cmd_t                      in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output owik_pkg::wheel_t                    out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [owik_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [owik_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // Truncating division of an exact Q15 sum by 2^15, rounding toward zero.
  function automatic logic signed [owik_pkg::WHEEL_W-1:0] trunc_q15(
    input logic signed [owik_pkg::SUM_W-1:0] s
  );
    logic signed [owik_pkg::SUM_W-1:0] bias;
    logic signed [owik_pkg::SUM_W-1:0] t;
    bias = s[owik_pkg::SUM_W-1] ? owik_pkg::SUM_W'(owik_pkg::TRUNC_BIAS) : '0;
    t    = (s + bias) >>> owik_pkg::FRAC_W;
    return t[owik_pkg::WHEEL_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. The host must only write them while idle; the
  // block does not enforce it, and the pipeline reads them directly.
  // --------------------------------------------------------------------------
  logic [owik_pkg::LIMIT_W-1:0]  speed_limit_q;
  logic [owik_pkg::RADIUS_W-1:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= owik_pkg::LIMIT_RESET;
      radius_q      <= owik_pkg::RADIUS_RESET;
    end else if (cfg_valid_i) begin
      unique case (owik_pkg::cfg_reg_e'(cfg_index_i))
        owik_pkg::CFG_SPEED_LIMIT:  speed_limit_q <= cfg_data_i[owik_pkg::LIMIT_W-1:0];
        owik_pkg::CFG_WHEEL_RADIUS: radius_q      <= cfg_data_i[owik_pkg::RADIUS_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Ready chain. Each stage accepts when it is empty or its word moves on.
  // --------------------------------------------------------------------------
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic div_in_ready;
  logic div_out_valid;
  owik_pkg::div_out_t div_out;

  assign rdy_out    = ~out_vld_q | out_ready_i;
  assign rdy4       = ~s4_vld_q | div_in_ready;
  assign rdy3       = ~s3_vld_q | rdy4;
  assign rdy2       = ~s2_vld_q | rdy3;
  assign rdy1       = ~s1_vld_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy1)    s1_vld_q  <= in_valid_i;
      if (rdy2)    s2_vld_q  <= s1_vld_q;
      if (rdy3)    s3_vld_q  <= s2_vld_q;
      if (rdy4)    s4_vld_q  <= s3_vld_q;
      if (rdy_out) out_vld_q <= div_out_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the coefficient products and the rotation product.
  // --------------------------------------------------------------------------
  logic signed [owik_pkg::PROD_W-1:0] s1_xh_q, s1_ys_q, xh_d, ys_d;
  logic signed [owik_pkg::CMD_W-1:0]  s1_x_q;
  logic signed [owik_pkg::ROT_W-1:0]  s1_rot_q, rot_d;
  logic                               s1_online_q;

  assign xh_d  = owik_pkg::PROD_W'(in_data_i.command_x)
               * owik_pkg::PROD_W'(owik_pkg::COEF_HALF);
  assign ys_d  = owik_pkg::PROD_W'(in_data_i.command_y)
               * owik_pkg::PROD_W'(owik_pkg::COEF_SQRT3_HALF);
  assign rot_d = owik_pkg::ROT_W'(in_data_i.command_turn)
               * owik_pkg::ROT_W'($signed({1'b0, radius_q}));

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_xh_q     <= xh_d;
      s1_ys_q     <= ys_d;
      s1_x_q      <= in_data_i.command_x;
      s1_rot_q    <= rot_d;
      s1_online_q <= in_data_i.motors_online;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: exact Q15 wheel sums, truncated toward zero to integer speeds.
  // --------------------------------------------------------------------------
  logic signed [owik_pkg::SUM_W-1:0]   x_full, rot_full, xh_full, ys_full;
  logic signed [owik_pkg::SUM_W-1:0]   sum0, sum1, sum2;
  logic signed [owik_pkg::WHEEL_W-1:0] w_d  [owik_pkg::LANES];
  logic signed [owik_pkg::WHEEL_W-1:0] s2_w_q [owik_pkg::LANES];
  logic                                s2_online_q;

  assign x_full   = owik_pkg::SUM_W'(s1_x_q) <<< owik_pkg::FRAC_W;
  assign rot_full = owik_pkg::SUM_W'(s1_rot_q) <<< owik_pkg::RADIUS_SHIFT;
  assign xh_full  = owik_pkg::SUM_W'(s1_xh_q);
  assign ys_full  = owik_pkg::SUM_W'(s1_ys_q);
  assign sum0     = -x_full - rot_full;
  assign sum1     = xh_full + ys_full - rot_full;
  assign sum2     = xh_full - ys_full - rot_full;

  assign w_d[0] = trunc_q15(sum0);
  assign w_d[1] = trunc_q15(sum1);
  assign w_d[2] = trunc_q15(sum2);

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_vld_q) begin
      s2_w_q      <= w_d;
      s2_online_q <= s1_online_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: magnitudes, signs and the largest magnitude.
  // --------------------------------------------------------------------------
  logic [owik_pkg::WHEEL_W-1:0] mag_d [owik_pkg::LANES];
  logic [owik_pkg::WHEEL_W-1:0] mx_d;
  logic [owik_pkg::WHEEL_W-1:0] s3_mag_q [owik_pkg::LANES];
  logic [owik_pkg::WHEEL_W-1:0] s3_mx_q;
  logic [owik_pkg::LANES-1:0]   s3_neg_q;
  logic [owik_pkg::OUT_W-1:0]   s3_wlow_q [owik_pkg::LANES];
  logic                         s3_online_q;

  always_comb begin
    for (int k = 0; k < owik_pkg::LANES; k++) begin
      mag_d[k] = s2_w_q[k][owik_pkg::WHEEL_W-1] ? owik_pkg::WHEEL_W'(-s2_w_q[k])
                                                : owik_pkg::WHEEL_W'(s2_w_q[k]);
    end
    mx_d = mag_d[0];
    if (mag_d[1] > mx_d) mx_d = mag_d[1];
    if (mag_d[2] > mx_d) mx_d = mag_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_vld_q) begin
      s3_mag_q    <= mag_d;
      s3_mx_q     <= mx_d;
      s3_online_q <= s2_online_q;
      for (int k = 0; k < owik_pkg::LANES; k++) begin
        s3_neg_q[k]  <= s2_w_q[k][owik_pkg::WHEEL_W-1];
        s3_wlow_q[k] <= s2_w_q[k][owik_pkg::OUT_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: the limit test and the dividends |w| * limit. The divider then
  // forms (|w| * limit) / max; the quotient never exceeds the limit.
  // --------------------------------------------------------------------------
  owik_pkg::div_in_t s4_data_q, s4_data_d;

  always_comb begin
    s4_data_d.divisor      = s3_mx_q;
    s4_data_d.side.neg     = s3_neg_q;
    s4_data_d.side.limited = s3_mx_q > owik_pkg::WHEEL_W'(speed_limit_q);
    s4_data_d.side.stopped = ~s3_online_q;
    for (int k = 0; k < owik_pkg::LANES; k++) begin
      s4_data_d.side.wlow[k] = s3_wlow_q[k];
      s4_data_d.num[k]       = owik_pkg::NUM_W'(s3_mag_q[k])
                             * owik_pkg::NUM_W'(speed_limit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_vld_q) begin
      s4_data_q <= s4_data_d;
    end
  end

  owik_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s4_vld_q),
    .in_ready_o  (div_in_ready),
    .in_data_i   (s4_data_q),
    .out_valid_o (div_out_valid),
    .out_ready_i (rdy_out),
    .out_data_o  (div_out)
  );

  // --------------------------------------------------------------------------
  // Output stage: pick the scaled quotient, the unscaled speed or zero.
  // --------------------------------------------------------------------------
  logic signed [owik_pkg::OUT_W-1:0] spd_d [owik_pkg::LANES];
  logic        [owik_pkg::OUT_W-1:0] quo_ext;
  owik_pkg::wheel_t                  out_q, out_d;

  always_comb begin
    for (int k = 0; k < owik_pkg::LANES; k++) begin
      quo_ext = owik_pkg::OUT_W'(div_out.quo[k]);
      if (div_out.side.stopped) begin
        spd_d[k] = '0;
      end else if (div_out.side.limited) begin
        spd_d[k] = div_out.side.neg[k] ? -quo_ext : quo_ext;
      end else begin
        spd_d[k] = div_out.side.wlow[k];
      end
    end
    out_d.wheel_speed_0 = spd_d[0];
    out_d.wheel_speed_1 = spd_d[1];
    out_d.wheel_speed_2 = spd_d[2];
    out_d.was_limited   = div_out.side.limited & ~div_out.side.stopped;
    out_d.stopped       = div_out.side.stopped;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out && div_out_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Checks on the delivered words.
  // --------------------------------------------------------------------------
  logic [owik_pkg::OUT_W:0] out_mag [owik_pkg::LANES];
  logic                     within_limit;

  always_comb begin
    out_mag[0] = out_q.wheel_speed_0[owik_pkg::OUT_W-1]
               ? -{1'b1, out_q.wheel_speed_0} : {1'b0, out_q.wheel_speed_0};
    out_mag[1] = out_q.wheel_speed_1[owik_pkg::OUT_W-1]
               ? -{1'b1, out_q.wheel_speed_1} : {1'b0, out_q.wheel_speed_1};
    out_mag[2] = out_q.wheel_speed_2[owik_pkg::OUT_W-1]
               ? -{1'b1, out_q.wheel_speed_2} : {1'b0, out_q.wheel_speed_2};
    within_limit = 1'b1;
    for (int k = 0; k < owik_pkg::LANES; k++) begin
      if (out_mag[k] > (owik_pkg::OUT_W + 1)'(speed_limit_q)) within_limit = 1'b0;
    end
  end

  a_stop_forces_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stopped |->
      (out_data_o.wheel_speed_0 == '0) && (out_data_o.wheel_speed_1 == '0) &&
      (out_data_o.wheel_speed_2 == '0) && !out_data_o.was_limited)
    else $error("stopped word carries nonzero speeds or a limit flag");

  a_speeds_within_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.stopped |-> within_limit)
    else $error("delivered wheel speed exceeds the speed limit");

  a_blocked_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && s1_vld_q && s4_vld_q)
    else $error("input refused while the pipeline has room");

endmodule

// ===== test/owik_checker.sv =====
// ============================================================================
// owik_checker: scoreboard of the omni-wheel inverse kinematics block
// Watches the command, result and configuration channels, predicts the wheel
// speeds of every accepted command word and compares each result word with
// the oldest prediction.
// ============================================================================
module owik_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  owik_pkg::cmd_t                  in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  owik_pkg::wheel_t                out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [owik_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [owik_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              fault_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import owik_pkg::*;

  localparam longint HALF_Q15       = 16384;
  localparam longint SQRT3_HALF_Q15 = 28378;
  localparam longint ONE_Q15        = 32768;

  logic [LIMIT_W-1:0]  speed_limit_q;
  logic [RADIUS_W-1:0] radius_q;
  wheel_t              pending_speeds[$];
  int                  fault_count;

  // Wheel speeds of one command under the given limit and radius. Division
  // truncates toward zero, as the block does.
  function automatic wheel_t compute_wheel_speeds(cmd_t cmd, logic [LIMIT_W-1:0] limit,
                                                  logic [RADIUS_W-1:0] radius);
    longint vx, vy, wz, rot, mx, lim;
    longint w[3];
    wheel_t res;
    res = '0;
    if (!cmd.motors_online) begin
      res.stopped = 1'b1;
      return res;
    end
    vx  = $signed(cmd.command_x);
    vy  = $signed(cmd.command_y);
    wz  = $signed(cmd.command_turn);
    rot = wz * longint'(radius) * 128;
    w[0] = (-vx * ONE_Q15 - rot) / ONE_Q15;
    w[1] = (vx * HALF_Q15 + vy * SQRT3_HALF_Q15 - rot) / ONE_Q15;
    w[2] = (vx * HALF_Q15 - vy * SQRT3_HALF_Q15 - rot) / ONE_Q15;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      if ((w[i] < 0 ? -w[i] : w[i]) > mx) mx = (w[i] < 0 ? -w[i] : w[i]);
    end
    lim = longint'(limit);
    if (mx > lim) begin
      res.was_limited = 1'b1;
      for (int i = 0; i < 3; i++) w[i] = (w[i] * lim) / mx;
    end
    res.wheel_speed_0 = 16'(w[0]);
    res.wheel_speed_1 = 16'(w[1]);
    res.wheel_speed_2 = 16'(w[2]);
    return res;
  endfunction

  task automatic check_field(string name, longint expv, longint actv);
    if (expv != actv) begin
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_t exp_w;
    if (!rst_ni) begin
      speed_limit_q = LIMIT_RESET;
      radius_q      = RADIUS_RESET;
      pending_speeds.delete();
      fault_count   = 0;
      fault_count_o <= 0;
      pending_o     <= 0;
    end else begin
      // Results are compared before new commands are queued, so that a result
      // arriving with an empty queue is never matched to the command of this edge.
      if (out_valid_i && out_ready_i) begin
        if (pending_speeds.size() == 0) begin
          fault_count++;
          $display("%0t: unexpected result word %h", $time, out_data_i);
        end else begin
          exp_w = pending_speeds.pop_front();
          check_field("wheel_speed_0", $signed(exp_w.wheel_speed_0),
                      $signed(out_data_i.wheel_speed_0));
          check_field("wheel_speed_1", $signed(exp_w.wheel_speed_1),
                      $signed(out_data_i.wheel_speed_1));
          check_field("wheel_speed_2", $signed(exp_w.wheel_speed_2),
                      $signed(out_data_i.wheel_speed_2));
          check_field("was_limited", exp_w.was_limited, out_data_i.was_limited);
          check_field("stopped", exp_w.stopped, out_data_i.stopped);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPEED_LIMIT:  speed_limit_q = cfg_data_i[LIMIT_W-1:0];
          CFG_WHEEL_RADIUS: radius_q      = cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pending_speeds.push_back(compute_wheel_speeds(in_data_i, speed_limit_q, radius_q));
      end
      fault_count_o <= fault_count;
      pending_o     <= pending_speeds.size();
    end
  end

endmodule

// ===== test/tb_omni_wheel_inverse_kinematics.sv =====
// ============================================================================
// tb_omni_wheel_inverse_kinematics: testbench of the omni-wheel kinematics
// Drives directed and random command words through several register settings
// with random idling on both channels; a checker beside the block predicts
// and compares every result word.
// ============================================================================
module tb_omni_wheel_inverse_kinematics;
  timeunit 1ns;
  timeprecision 1ps;

  import owik_pkg::*;

  // Random part: eight phases with a fresh register setting each.
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 244;
  localparam int CALM_FIRST = 700;
  localparam int CALM_LAST  = 1000;
  // Cycles to wait after the last result, more than the pipeline depth.
  localparam int TAIL_CYCLES = 40;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  cmd_t                  in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  wheel_t                out_data;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  // While calm is high neither side idles.
  logic                  calm        = 1'b0;
  int                    fault_count;
  int                    pending;

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  omni_wheel_inverse_kinematics u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  owik_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fault_count_o (fault_count),
    .pending_o     (pending)
  );

  // The receiver stalls with a probability of about 37 percent, except while calm.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 37);
  end

  function automatic cmd_t make_cmd(int x, int y, int turn, bit online);
    cmd_t c;
    c.command_x     = 16'(x);
    c.command_y     = 16'(y);
    c.command_turn  = 16'(turn);
    c.motors_online = online;
    return c;
  endfunction

  // Random command: mostly full-range values, which are usually limited, some
  // small values that usually pass unscaled, some single-axis commands, and now and
  // then an offline motor.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   mode;
    mode            = $urandom_range(9);
    c.command_x     = 16'($urandom);
    c.command_y     = 16'($urandom);
    c.command_turn  = 16'($urandom);
    c.motors_online = ($urandom_range(9) != 0);
    if (mode < 3) begin
      c.command_x    = 16'(int'($urandom_range(4095)) - 2048);
      c.command_y    = 16'(int'($urandom_range(4095)) - 2048);
      c.command_turn = 16'(int'($urandom_range(4095)) - 2048);
    end else if (mode < 5) begin
      case ($urandom_range(2))
        0: begin
          c.command_y    = '0;
          c.command_turn = '0;
        end
        1: begin
          c.command_x    = '0;
          c.command_turn = '0;
        end
        default: begin
          c.command_x = '0;
          c.command_y = '0;
        end
      endcase
    end
    return c;
  endfunction

  // Offers one command word. Valid is lowered only in idle cycles in front of
  // the word, so it is never lowered and raised at the same edge.
  task automatic send_cmd(cmd_t c);
    while (!calm && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the command channel and waits until every predicted word has come
  // back. Each command yields one result, so nothing is left in flight then.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] limit_word;
    logic [CFG_DATA_W-1:0] radius_word;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: limit 8000, radius 1.0. A still chassis, axis extremes,
    // all fields at their extremes, a small command that passes unscaled, and
    // offline motors with large commands that must still give zeros.
    send_cmd(make_cmd(0, 0, 0, 1'b1));
    send_cmd(make_cmd(32767, 32767, 32767, 1'b1));
    send_cmd(make_cmd(-32768, -32768, -32768, 1'b1));
    send_cmd(make_cmd(-32768, 0, 0, 1'b1));
    send_cmd(make_cmd(0, 32767, 0, 1'b1));
    send_cmd(make_cmd(0, 0, -32768, 1'b1));
    send_cmd(make_cmd(-1, -1, -1, 1'b1));
    send_cmd(make_cmd(100, 200, 50, 1'b1));
    send_cmd(make_cmd(32767, -32768, 32767, 1'b0));
    send_cmd(make_cmd(-32768, 32767, -32768, 1'b0));
    wait_idle();

    // Widest legal setting: the largest limit and the largest legal radius.
    write_cfg(CFG_SPEED_LIMIT, 16'd32767);
    write_cfg(CFG_WHEEL_RADIUS, 16'd1024);
    send_cmd(make_cmd(32767, 32767, 32767, 1'b1));
    send_cmd(make_cmd(-32768, -32768, -32768, 1'b1));
    send_cmd(make_cmd(32767, -32768, 0, 1'b1));
    send_cmd(make_cmd(1, 1, 1, 1'b1));
    wait_idle();

    // Limit of zero with radius zero: any nonzero wheel is scaled to zero and
    // the turn command has no effect.
    write_cfg(CFG_SPEED_LIMIT, 16'd0);
    write_cfg(CFG_WHEEL_RADIUS, 16'd0);
    send_cmd(make_cmd(0, 0, 0, 1'b1));
    send_cmd(make_cmd(0, 0, 32767, 1'b1));
    send_cmd(make_cmd(1, 0, 0, 1'b1));
    send_cmd(make_cmd(-32768, 32767, -32768, 1'b1));
    wait_idle();

    // All data bits set: bits above each register's width are dropped, which
    // leaves limit 32767 and the oversized radius 2047.
    write_cfg(CFG_SPEED_LIMIT, 16'hFFFF);
    write_cfg(CFG_WHEEL_RADIUS, 16'hFFFF);
    send_cmd(make_cmd(0, 0, 32767, 1'b1));
    send_cmd(make_cmd(0, 0, -32768, 1'b1));
    send_cmd(make_cmd(-32768, -32768, 32767, 1'b1));

    // Random part. Each phase begins with a drained pipeline and a new
    // setting; the limit spans its whole legal range and the radius is now
    // and then taken from all eleven bits. Upper data bits are random.
    for (int k = 0; k < PHASES * PHASE_LEN; k++) begin
      if (k % PHASE_LEN == 0) begin
        wait_idle();
        limit_word  = {1'($urandom), 15'($urandom_range(32767, 1))};
        radius_word = {5'($urandom), 11'($urandom_range(1024, 1))};
        if ($urandom_range(3) == 0) radius_word[RADIUS_W-1:0] = 11'($urandom);
        if ($urandom_range(3) == 0) limit_word[LIMIT_W-1:0] = 15'($urandom_range(300, 1));
        write_cfg(CFG_SPEED_LIMIT, limit_word);
        write_cfg(CFG_WHEEL_RADIUS, radius_word);
      end
      calm <= (k >= CALM_FIRST) && (k < CALM_LAST);
      send_cmd(random_cmd());
    end

    wait_idle();
    calm <= 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending == 0) begin
      $display("omni_wheel_inverse_kinematics verification clean");
    end else begin
      $display("omni_wheel_inverse_kinematics verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("omni_wheel_inverse_kinematics verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/owik_pkg.sv
rtl/owik_divider.sv
rtl/omni_wheel_inverse_kinematics.sv
test/owik_checker.sv
test/tb_omni_wheel_inverse_kinematics.sv
